// ===== src/stack_with_min_max_mean_top_assert.svh =====
// Assertion macros shared by the stack block's modules.
`ifndef STACK_WITH_MIN_MAX_MEAN_TOP_ASSERT_SVH
`define STACK_WITH_MIN_MAX_MEAN_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a condition at every clock edge outside reset.
`define SMMM_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("stack block: invariant violated");
// Check a consequence in the same cycle as its cause.
`define SMMM_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stack block: implication violated");
// Check a consequence in the cycle after its cause.
`define SMMM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stack block: next-cycle implication violated");
`else
`define SMMM_ASSERT_ALWAYS(lbl, expr)
`define SMMM_ASSERT_IMPLIES(lbl, ante, cons)
`define SMMM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/smmm_pkg.sv =====
// Types and constants shared by the stack block's modules.
package smmm_pkg;

  localparam int VAL_W   = 32;
  localparam int ENTRY_W = 7;
  localparam int CMD_W   = 2;
  // Command queue depth between front and back; a power of two.
  localparam int Q_DEPTH = 2;

  // Request opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Classified commands handed from front to back
  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REJECT = 2'd2;

  typedef struct packed {
    logic                    op;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic                    ok;
    logic signed [VAL_W-1:0] popped_value;
    logic [ENTRY_W-1:0]      entry_count;
    logic signed [VAL_W-1:0] max_value;
    logic signed [VAL_W-1:0] min_value;
    logic signed [VAL_W-1:0] mean_value;
    logic                    is_empty;
  } out_t;

  typedef struct packed {
    logic [CMD_W-1:0]        code;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

endpackage

// ===== src/smmm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module smmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/smmm_div.sv =====
// Bit-serial signed divider for the running mean, one quotient bit per cycle.
module smmm_div #(
  parameter int SUM_W = 38,
  parameter int CNT_W = 7
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [SUM_W-1:0]          dividend,
  input  logic [CNT_W-1:0]                 divisor,
  output logic                             done,
  output logic signed [smmm_pkg::VAL_W-1:0] quotient
);

  import smmm_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  mag_r, mag_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  div_r, div_nxt;
  logic              neg_r, neg_nxt;

  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_diff;
  logic              fits;
  logic [VAL_W-1:0]  q_mag;

  // Shift in one dividend bit and try a subtract
  assign rem_sh   = {rem_r, mag_r[SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, div_r};
  assign fits     = rem_sh >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    if (start) begin
      // Load magnitude and sign of the sum
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(SUM_W - 1);
      neg_nxt  = dividend[SUM_W-1];
      mag_nxt  = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      mag_nxt = {mag_r[SUM_W-2:0], fits};
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    mag_r  <= mag_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    neg_r  <= neg_nxt;
  end

  // Apply the sign; the mean always fits the value width
  assign q_mag    = mag_r[VAL_W-1:0];
  assign quotient = neg_r ? -q_mag : q_mag;
  assign done     = done_r;

  `include "stack_with_min_max_mean_top_assert.svh"

  `SMMM_ASSERT_NEXT(a_div_finish, busy_r && !start && (step_r == '0), done_r && !busy_r)

endmodule

// ===== src/smmm_front.sv =====
// Front end: accepts requests, classifies them against a shadow count and queues them.
module smmm_front #(
  parameter int STACK_DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  smmm_pkg::in_t   in_data,
  output logic            q_valid,
  output smmm_pkg::cmd_t  q_cmd,
  input  logic            q_take
);

  import smmm_pkg::*;

  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int QAW = $clog2(Q_DEPTH);
  localparam int QCW = $clog2(Q_DEPTH + 1);

  logic [CW-1:0]  shadow_r, shadow_nxt;
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] q_cnt_r, q_cnt_nxt;
  cmd_t           q_mem_r [Q_DEPTH];

  logic           acc;
  cmd_t           cls;

  assign in_stall = (q_cnt_r == QCW'(Q_DEPTH));
  assign acc      = in_valid && !in_stall;

  // Classify the request against the count it will meet in the back end
  always_comb begin
    cls.value = in_data.value;
    unique case (in_data.op)
      OP_PUSH: cls.code = (shadow_r < CW'(STACK_DEPTH)) ? CMD_PUSH : CMD_REJECT;
      OP_POP:  cls.code = (shadow_r != '0) ? CMD_POP : CMD_REJECT;
      default: cls.code = CMD_REJECT;
    endcase
  end

  // Advance the shadow count for every queued push or pop
  always_comb begin
    shadow_nxt = shadow_r;
    if (acc) begin
      case (cls.code)
        CMD_PUSH: shadow_nxt = shadow_r + CW'(1);
        CMD_POP:  shadow_nxt = shadow_r - CW'(1);
        default:  shadow_nxt = shadow_r;
      endcase
    end
  end

  // Track queue occupancy
  always_comb begin
    q_cnt_nxt = q_cnt_r;
    if (acc && !q_take) begin
      q_cnt_nxt = q_cnt_r + QCW'(1);
    end else if (!acc && q_take) begin
      q_cnt_nxt = q_cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shadow_r <= '0;
      q_cnt_r  <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      shadow_r <= shadow_nxt;
      q_cnt_r  <= q_cnt_nxt;
      if (acc) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (q_take) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
    end
  end

  // Hold queued commands
  always_ff @(posedge clk) begin
    if (acc) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

  assign q_valid = (q_cnt_r != '0);
  assign q_cmd   = q_mem_r[rd_ptr_r];

endmodule

// ===== src/smmm_back.sv =====
// Back end: carries out queued commands on the stack, side stacks and running sum.
module smmm_back #(
  parameter int STACK_DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  smmm_pkg::cmd_t  q_cmd,
  output logic            q_take,
  output logic            out_valid,
  input  logic            out_stall,
  output smmm_pkg::out_t  out_data
);

  import smmm_pkg::*;

  localparam int CW    = $clog2(STACK_DEPTH + 1);
  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int SW    = VAL_W + $clog2(STACK_DEPTH);
  localparam int ROW_W = 3 * VAL_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FETCH  = 3'd1;
  localparam logic [2:0] ST_MEAN   = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic signed [SW-1:0]    sum_r, sum_nxt;
  logic signed [VAL_W-1:0] top_val_r, top_val_nxt;
  logic signed [VAL_W-1:0] top_max_r, top_max_nxt;
  logic signed [VAL_W-1:0] top_min_r, top_min_nxt;
  logic signed [VAL_W-1:0] mean_r, mean_nxt;
  logic signed [VAL_W-1:0] popped_r, popped_nxt;
  logic                    ok_r, ok_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_t                    out_data_r;

  logic [CW-1:0]           cnt_m1, cnt_m2;
  logic signed [VAL_W-1:0] push_max, push_min;
  logic                    ram_we, ram_re;
  logic [ROW_W-1:0]        ram_rdata;
  logic                    div_start, div_done;
  logic signed [VAL_W-1:0] div_quot;
  logic                    out_free, out_load, empty;
  logic [CW+ENTRY_W-1:0]   cnt_wide;
  out_t                    result;

  assign cnt_m1    = cnt_r - CW'(1);
  assign cnt_m2    = cnt_r - CW'(2);
  assign q_take    = (state_r == ST_IDLE) && q_valid;
  assign div_start = (state_r == ST_MEAN);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == ST_RESULT) && out_free;

  // Extremes of the new top level on a push
  assign push_max = (cnt_r == '0 || q_cmd.value > top_max_r) ? q_cmd.value : top_max_r;
  assign push_min = (cnt_r == '0 || q_cmd.value < top_min_r) ? q_cmd.value : top_min_r;

  // Spill the cached top row below a push; refill it from the level under a pop
  assign ram_we = q_take && (q_cmd.code == CMD_PUSH) && (cnt_r != '0);
  assign ram_re = q_take && (q_cmd.code == CMD_POP) && (cnt_r >= CW'(2));

  smmm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (STACK_DEPTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_m1[AW-1:0]),
    .wdata ({top_val_r, top_max_r, top_min_r}),
    .re    (ram_re),
    .raddr (cnt_m2[AW-1:0]),
    .rdata (ram_rdata)
  );

  smmm_div #(
    .SUM_W (SW),
    .CNT_W (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Sequence one command at a time
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    sum_nxt     = sum_r;
    top_val_nxt = top_val_r;
    top_max_nxt = top_max_r;
    top_min_nxt = top_min_r;
    mean_nxt    = mean_r;
    popped_nxt  = popped_r;
    ok_nxt      = ok_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.code)
            CMD_PUSH: begin
              top_val_nxt = q_cmd.value;
              top_max_nxt = push_max;
              top_min_nxt = push_min;
              cnt_nxt     = cnt_r + CW'(1);
              sum_nxt     = sum_r + SW'(q_cmd.value);
              ok_nxt      = 1'b1;
              popped_nxt  = '0;
              state_nxt   = ST_MEAN;
            end
            CMD_POP: begin
              popped_nxt = top_val_r;
              cnt_nxt    = cnt_m1;
              sum_nxt    = sum_r - SW'(top_val_r);
              ok_nxt     = 1'b1;
              state_nxt  = (cnt_r >= CW'(2)) ? ST_FETCH : ST_RESULT;
            end
            default: begin
              // Rejected request (and unused codes): stack untouched
              ok_nxt     = 1'b0;
              popped_nxt = '0;
              state_nxt  = ST_RESULT;
            end
          endcase
        end
      end
      ST_FETCH: begin
        top_val_nxt = ram_rdata[ROW_W-1 -: VAL_W];
        top_max_nxt = ram_rdata[2*VAL_W-1 -: VAL_W];
        top_min_nxt = ram_rdata[VAL_W-1:0];
        state_nxt   = ST_MEAN;
      end
      ST_MEAN: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          mean_nxt  = div_quot;
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Build the result; statistics read zero on an empty stack
  assign empty    = (cnt_r == '0);
  assign cnt_wide = {{ENTRY_W{1'b0}}, cnt_r};

  always_comb begin
    result.ok           = ok_r;
    result.popped_value = popped_r;
    result.entry_count  = cnt_wide[ENTRY_W-1:0];
    result.max_value    = empty ? '0 : top_max_r;
    result.min_value    = empty ? '0 : top_min_r;
    result.mean_value   = empty ? '0 : mean_r;
    result.is_empty     = empty;
  end

  // Output register: load a finished result, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_val_r <= top_val_nxt;
    top_max_r <= top_max_nxt;
    top_min_r <= top_min_nxt;
    mean_r    <= mean_nxt;
    popped_r  <= popped_nxt;
    ok_r      <= ok_nxt;
    if (out_load) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `include "stack_with_min_max_mean_top_assert.svh"

  `SMMM_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CW'(STACK_DEPTH))
  `SMMM_ASSERT_IMPLIES(a_div_nonzero, div_start, cnt_r != '0)
  `SMMM_ASSERT_IMPLIES(a_fetch_after_pop, state_r == ST_FETCH, $past(ram_re))

endmodule

// ===== src/stack_with_min_max_mean_top.sv =====
// Top level of the bounded stack with running maximum, minimum and mean.
//
// Input channel (in_valid / in_stall / in_data): one request per item, a push of
// in_data.value or a pop. Result channel (out_valid / out_stall / out_data): one
// result per request, in order, giving success, the popped value, the entry
// count and the maximum, minimum and mean of the stored entries.
// A two-entry command queue sits between the front end and the back end, so
// requests are still accepted while a result waits on a stalled receiver.
// From acceptance a request passes through the command queue to the back end.
// A successful push then steps through the mean and divide states, a pop that
// leaves entries first fetches the new top row from the row memory, and a pop
// that empties the stack or a rejected request goes straight to the result
// state. Requests are carried out one at a time, so the back end takes no new
// command until the last result is loaded; the bit-serial mean divider yields
// one quotient bit per cycle.
// Reset empties the stack at once; no clearing pass runs over the row memory.
// While out_stall is high the result register holds and the queue fills, then
// in_stall rises.
module stack_with_min_max_mean_top #(
  parameter int STACK_DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  smmm_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output smmm_pkg::out_t  out_data
);

  import smmm_pkg::*;

  logic q_valid;
  logic q_take;
  cmd_t q_cmd;

  smmm_front #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_take   (q_take)
  );

  smmm_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_take    (q_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
